/* src/toeq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// toeq_pkg: shared types and constants of the time ordered event queue
// Table geometry, entry layout, command and status codes, sequencer states
// and the compare unit result.
// -----------------------------------------------------------------------------
package toeq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int TIME_W      = 32;
	localparam int ID_PORT_W   = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ID_BITS-1:0] eid_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		eid_t              id;
	} ent_t;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_ADVANCE  = 3'd2,
		CMD_LIST_ALL = 3'd3,
		CMD_LIST_AT  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ITEM = 3'd0,
		ST_DONE = 3'd1,
		ST_PAST = 3'd2,
		ST_FULL = 3'd3,
		ST_NONE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_RD,
		S_EV,
		S_PUT,
		S_DRD,
		S_DEV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic eq;
		logic le;
	} cmp_t;

endpackage
`default_nettype wire

/* src/toeq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// toeq_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module toeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* src/toeq_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// toeq_cmp: shared time comparator
// Unsigned equal and less-or-equal of two due times.
// -----------------------------------------------------------------------------
module toeq_cmp (
	input  logic [toeq_pkg::TIME_W-1:0] a,
	input  logic [toeq_pkg::TIME_W-1:0] b,
	output toeq_pkg::cmp_t              res
);
	import toeq_pkg::*;

	assign res.eq = (a == b);
	assign res.le = (a <= b);

endmodule
`default_nettype wire

/* src/time_ordered_event_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// time_ordered_event_queue_unit: sorted timer event queue
// Holds up to QUEUE_DEPTH events sorted by due time and a wrapping current
// time; adds, removes, advances and lists under a small sequencer.
// -----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the final result of that command has been issued. Results appear one
// per strobe cycle and cannot be held off, so the receiver must take every
// strobe; last marks the final result of a command. Cost per command is set by
// the event table with one write and one read port and registered read and the
// one shared time comparator. An add reads and moves up each later entry in
// turn, reads the earlier entry it stops at, if any, then writes the new one;
// remove and the list commands read every stored entry once; an advance does
// the same and checks each due entry after the first against earlier entries
// (the first entry of the current run of equal due times, then onward through
// that run until a repeat is found); unknown commands, a past add and an add
// to a full table finish without reading the table.
// -----------------------------------------------------------------------------
module time_ordered_event_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] time_value,
	input  logic [15:0] event_id,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [31:0] out_time,
	output logic [15:0] out_id,
	output logic        last
);
	import toeq_pkg::*;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [TIME_W-1:0] tv_q;
	eid_t              id_q;
	logic [TIME_W-1:0] now_q;
	cnt_t              cnt_q, idx_q, keep_q, grp_q, j_q;
	logic              any_q, pend_v_q;
	ent_t              pend_q, cur_q;

	logic              strobe_q, last_q;
	status_t           status_q;
	logic [TIME_W-1:0] out_time_q;
	logic [15:0]       out_id_q;

	logic              we;
	addr_t             wa, ra;
	ent_t              wd, rd_ent;
	logic [TIME_W-1:0] ca, cb;
	cmp_t              cmp_r;

	logic              emit, e_last;
	status_t           e_status;
	logic [TIME_W-1:0] e_time;
	logic [15:0]       e_id;

	cnt_t              idx_m1, nidx, nj;
	logic              at_end, j_end, id_eq, matched;

	toeq_ram #(
		.WIDTH($bits(ent_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wa),
		.wdata(wd),
		.raddr(ra),
		.rdata(rd_ent)
	);

	toeq_cmp u_cmp (
		.a  (ca),
		.b  (cb),
		.res(cmp_r)
	);

	assign idx_m1  = idx_q - 1'b1;
	assign nidx    = idx_q + 1'b1;
	assign nj      = j_q + 1'b1;
	assign at_end  = (nidx == cnt_q);
	assign j_end   = (nj == idx_q);
	assign id_eq   = (rd_ent.id == cur_q.id);
	assign matched = (cmd_q == CMD_LIST_ALL) || cmp_r.eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		e_last   = 1'b0;
		e_status = ST_DONE;
		e_time   = '0;
		e_id     = '0;
		we       = 1'b0;
		wa       = idx_q[ADDR_W-1:0];
		wd       = rd_ent;
		ra       = idx_q[ADDR_W-1:0];
		ca       = tv_q;
		cb       = now_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				unique case (cmd_q) inside
					CMD_ADD: begin
						if (cmp_r.le) begin
							emit     = 1'b1;
							e_last   = 1'b1;
							e_status = ST_PAST;
							state_d  = S_IDLE;
						end else if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
							emit     = 1'b1;
							e_last   = 1'b1;
							e_status = ST_FULL;
							state_d  = S_IDLE;
						end else if (cnt_q == '0) begin
							state_d = S_PUT;
						end else begin
							state_d = S_RD;
						end
					end
					CMD_REMOVE, CMD_ADVANCE, CMD_LIST_ALL, CMD_LIST_AT: begin
						state_d = (cnt_q == '0) ? S_FIN : S_RD;
					end
					default: begin
						emit    = 1'b1;
						e_last  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_RD: begin
				ra      = (cmd_q == CMD_ADD) ? idx_m1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
				state_d = S_EV;
			end
			S_EV: begin
				ca = rd_ent.t;
				cb = (cmd_q == CMD_ADVANCE) ? now_q : tv_q;
				unique case (cmd_q) inside
					CMD_ADD: begin
						if (cmp_r.le) begin
							state_d = S_PUT;
						end else begin
							we      = 1'b1;
							state_d = (idx_q == cnt_t'(1)) ? S_PUT : S_RD;
						end
					end
					CMD_REMOVE: begin
						if (!cmp_r.eq) begin
							we = 1'b1;
							wa = keep_q[ADDR_W-1:0];
						end
						state_d = at_end ? S_FIN : S_RD;
					end
					CMD_ADVANCE: begin
						if (cmp_r.le) begin
							if (grp_q == idx_q) begin
								if (pend_v_q) begin
									emit     = 1'b1;
									e_status = ST_ITEM;
									e_time   = pend_q.t;
									e_id     = ID_PORT_W'(pend_q.id);
								end
								state_d = at_end ? S_FIN : S_RD;
							end else begin
								state_d = S_DRD;
							end
						end else begin
							we      = 1'b1;
							wa      = keep_q[ADDR_W-1:0];
							state_d = at_end ? S_FIN : S_RD;
						end
					end
					CMD_LIST_ALL, CMD_LIST_AT: begin
						if (matched && pend_v_q) begin
							emit     = 1'b1;
							e_status = ST_ITEM;
							e_time   = pend_q.t;
							e_id     = ID_PORT_W'(pend_q.id);
						end
						state_d = at_end ? S_FIN : S_RD;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_DRD: begin
				ra      = j_q[ADDR_W-1:0];
				state_d = S_DEV;
			end
			S_DEV: begin
				ca = rd_ent.t;
				cb = cur_q.t;
				if (cmp_r.eq && id_eq) begin
					state_d = at_end ? S_FIN : S_RD;
				end else if (!cmp_r.eq || j_end) begin
					if (pend_v_q) begin
						emit     = 1'b1;
						e_status = ST_ITEM;
						e_time   = pend_q.t;
						e_id     = ID_PORT_W'(pend_q.id);
					end
					state_d = at_end ? S_FIN : S_RD;
				end else begin
					state_d = S_DRD;
				end
			end
			S_PUT: begin
				we       = 1'b1;
				wd.t     = tv_q;
				wd.id    = id_q;
				emit     = 1'b1;
				e_last   = 1'b1;
				state_d  = S_IDLE;
			end
			S_FIN: begin
				emit   = 1'b1;
				e_last = 1'b1;
				if (pend_v_q) begin
					e_status = ST_ITEM;
					e_time   = pend_q.t;
					e_id     = ID_PORT_W'(pend_q.id);
				end else if (cmd_q == CMD_ADVANCE) begin
					e_status = ST_DONE;
				end else if (cmd_q == CMD_REMOVE && any_q) begin
					e_status = ST_DONE;
				end else begin
					e_status = ST_NONE;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			now_q    <= '0;
			pend_v_q <= 1'b0;
			any_q    <= 1'b0;
			cmd_q    <= CMD_ADD;
			tv_q     <= '0;
			id_q     <= '0;
			idx_q    <= '0;
			keep_q   <= '0;
			grp_q    <= '0;
			j_q      <= '0;
			pend_q   <= '0;
			cur_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd_t'(cmd);
						tv_q     <= time_value;
						id_q     <= eid_t'(event_id);
						idx_q    <= '0;
						keep_q   <= '0;
						grp_q    <= '0;
						j_q      <= '0;
						any_q    <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				S_PRE: begin
					if (cmd_q == CMD_ADD) begin
						idx_q <= cnt_q;
					end
					if (cmd_q == CMD_ADVANCE) begin
						now_q <= now_q + tv_q;
					end
				end
				S_EV: begin
					case (cmd_q) inside
						CMD_ADD: begin
							if (!cmp_r.le) begin
								idx_q <= idx_m1;
							end
						end
						CMD_REMOVE: begin
							if (cmp_r.eq) begin
								any_q <= 1'b1;
							end else begin
								keep_q <= keep_q + 1'b1;
							end
							idx_q <= nidx;
						end
						CMD_ADVANCE: begin
							if (cmp_r.le) begin
								cur_q <= rd_ent;
								j_q   <= grp_q;
								if (grp_q == idx_q) begin
									pend_q   <= rd_ent;
									pend_v_q <= 1'b1;
									idx_q    <= nidx;
								end
							end else begin
								keep_q <= keep_q + 1'b1;
								idx_q  <= nidx;
							end
						end
						CMD_LIST_ALL, CMD_LIST_AT: begin
							if (matched) begin
								pend_q   <= rd_ent;
								pend_v_q <= 1'b1;
							end
							idx_q <= nidx;
						end
						default: begin
							idx_q <= idx_q;
						end
					endcase
				end
				S_DEV: begin
					if (cmp_r.eq && id_eq) begin
						idx_q <= nidx;
					end else if (!cmp_r.eq || j_end) begin
						if (!cmp_r.eq) begin
							grp_q <= idx_q;
						end
						pend_q   <= cur_q;
						pend_v_q <= 1'b1;
						idx_q    <= nidx;
					end else begin
						j_q <= nj;
					end
				end
				S_PUT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				S_FIN: begin
					if (cmd_q == CMD_REMOVE || cmd_q == CMD_ADVANCE) begin
						cnt_q <= keep_q;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= e_status;
			out_time_q <= e_time;
			out_id_q   <= e_id;
			last_q     <= e_last;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign strobe   = strobe_q;
	assign status   = status_q;
	assign out_time = out_time_q;
	assign out_id   = out_id_q;
	assign last     = last_q;

endmodule
`default_nettype wire

/* src/toeq_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// toeq_chk: port level checks of the event queue
// Relates start, busy and the result strobe over time.
// -----------------------------------------------------------------------------
module toeq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  status,
	input logic [31:0] out_time,
	input logic [15:0] out_id,
	input logic        last
);
	import toeq_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("intermediate result while idle");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_ITEM) |-> last)
		else $error("non-item result not final");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_ITEM) |-> (out_time == '0) && (out_id == '0))
		else $error("non-item result carries event fields");

endmodule

bind time_ordered_event_queue_unit toeq_chk u_toeq_chk (.*);
`default_nettype wire

/* tb/time_ordered_event_queue_unit_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// time_ordered_event_queue_unit_tb: self-checking bench for the event queue
// Feeds directed and random add, remove, advance and list commands through
// the start/busy handshake in bursts with random gaps. A shadow copy of the
// sorted event table predicts every result, and each strobed result is
// checked field by field against the oldest prediction.
// -----------------------------------------------------------------------------
module time_ordered_event_queue_unit_tb;

	import toeq_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          TAIL_CYCLES   = 64;
	localparam int          ITEM_TARGET   = 330;
	localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]  c;
		logic [31:0] tv;
		logic [15:0] id;
		bit          drain;
	} cmd_item_t;

	typedef struct {
		status_t     st;
		logic [31:0] t;
		logic [15:0] id;
		logic        lst;
		longint      acc_cyc;
	} event_report_t;

	logic        clk;
	logic        arst_n;
	logic        start      = 1'b0;
	logic [2:0]  cmd        = '0;
	logic [31:0] time_value = '0;
	logic [15:0] event_id   = '0;
	logic        busy;
	logic        strobe;
	logic [2:0]  status;
	logic [31:0] out_time;
	logic [15:0] out_id;
	logic        last;

	cmd_item_t     cmd_backlog[$];
	event_report_t due_reports[$];

	logic [31:0] sched_time[QUEUE_DEPTH];
	eid_t        sched_id[QUEUE_DEPTH];
	int          sched_count = 0;
	logic [31:0] clock_now   = '0;

	logic [31:0] gen_now = '0;
	logic [31:0] gen_times[$];

	longint cyc            = 0;
	longint reports_queued = 0;
	longint reports_seen   = 0;
	int     err_count      = 0;
	int     burst_left     = 0;
	int     gap_left       = 0;

	time_ordered_event_queue_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.time_value (time_value),
		.event_id   (event_id),
		.strobe     (strobe),
		.status     (status),
		.out_time   (out_time),
		.out_id     (out_id),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0d: %s", cyc, msg);
		err_count++;
	endtask

	function automatic event_report_t make_report(input status_t s, input logic [31:0] t,
			input logic [15:0] id);
		event_report_t r;
		r.st      = s;
		r.t       = t;
		r.id      = id;
		r.lst     = 1'b0;
		r.acc_cyc = 0;
		return r;
	endfunction

	// shadow of the sorted table; appends the predicted results of one command
	task automatic apply_command(input logic [2:0] c, input logic [31:0] tv,
			input logic [15:0] idin);
		event_report_t loc[$];
		logic [31:0]   ft[QUEUE_DEPTH];
		eid_t          fi[QUEUE_DEPTH];
		eid_t          idm;
		int            i;
		int            j;
		int            pos;
		int            keep;
		int            nf;
		bit            dup;
		bit            hit;
		idm  = eid_t'(idin);
		keep = 0;
		nf   = 0;
		hit  = 1'b0;
		case (c) inside
			CMD_ADD: begin
				if (tv <= clock_now) begin
					loc.insert(loc.size(), make_report(ST_PAST, '0, '0));
				end else if (sched_count >= QUEUE_DEPTH) begin
					loc.insert(loc.size(), make_report(ST_FULL, '0, '0));
				end else begin
					pos = 0;
					while (pos < sched_count && sched_time[pos] <= tv)
						pos++;
					for (i = sched_count; i > pos; i--) begin
						sched_time[i] = sched_time[i-1];
						sched_id[i]   = sched_id[i-1];
					end
					sched_time[pos] = tv;
					sched_id[pos]   = idm;
					sched_count++;
					loc.insert(loc.size(), make_report(ST_DONE, '0, '0));
				end
			end
			CMD_REMOVE: begin
				for (i = 0; i < sched_count; i++) begin
					if (sched_time[i] == tv) begin
						hit = 1'b1;
					end else begin
						sched_time[keep] = sched_time[i];
						sched_id[keep]   = sched_id[i];
						keep++;
					end
				end
				sched_count = keep;
				loc.insert(loc.size(), make_report(hit ? ST_DONE : ST_NONE, '0, '0));
			end
			CMD_ADVANCE: begin
				clock_now = clock_now + tv;
				for (i = 0; i < sched_count; i++) begin
					if (sched_time[i] <= clock_now) begin
						dup = 1'b0;
						for (j = 0; j < nf; j++)
							if (ft[j] == sched_time[i] && fi[j] == sched_id[i])
								dup = 1'b1;
						if (!dup) begin
							ft[nf] = sched_time[i];
							fi[nf] = sched_id[i];
							nf++;
							loc.insert(loc.size(), make_report(ST_ITEM, sched_time[i],
								16'(sched_id[i])));
						end
					end else begin
						sched_time[keep] = sched_time[i];
						sched_id[keep]   = sched_id[i];
						keep++;
					end
				end
				sched_count = keep;
				if (loc.size() == 0)
					loc.insert(loc.size(), make_report(ST_DONE, '0, '0));
			end
			CMD_LIST_ALL, CMD_LIST_AT: begin
				for (i = 0; i < sched_count; i++)
					if (c == CMD_LIST_ALL || sched_time[i] == tv)
						loc.insert(loc.size(), make_report(ST_ITEM, sched_time[i],
							16'(sched_id[i])));
				if (loc.size() == 0)
					loc.insert(loc.size(), make_report(ST_NONE, '0, '0));
			end
			default: begin
				loc.insert(loc.size(), make_report(ST_DONE, '0, '0));
			end
		endcase
		loc[loc.size()-1].lst = 1'b1;
		foreach (loc[k]) begin
			loc[k].acc_cyc = cyc;
			due_reports.insert(due_reports.size(), loc[k]);
		end
		reports_queued += loc.size();
	endtask

	task automatic queue_cmd(input logic [2:0] c, input logic [31:0] tv,
			input logic [15:0] id, input bit drain);
		cmd_item_t it;
		it.c     = c;
		it.tv    = tv;
		it.id    = id;
		it.drain = drain;
		cmd_backlog.insert(cmd_backlog.size(), it);
		if (c == CMD_ADVANCE)
			gen_now = gen_now + tv;
		if (c == CMD_ADD && tv > gen_now) begin
			gen_times.insert(gen_times.size(), tv);
			if (gen_times.size() > 12)
				void'(gen_times.pop_front());
		end
	endtask

	function automatic logic [31:0] recent_time();
		if (gen_times.size() > 0 && $urandom_range(0, 3) != 0)
			return gen_times[$urandom_range(0, gen_times.size() - 1)];
		return gen_now + $urandom_range(0, 64);
	endfunction

	always @(posedge clk)
		cyc <= cyc + 1;

	always @(posedge clk) begin
		if (cyc >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// hold start until the item is taken; pause for gaps and drain requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			cmd        <= '0;
			time_value <= '0;
			event_id   <= '0;
		end else begin : drive
			cmd_item_t nx;
			logic      go;
			go = start;
			if (start && !busy) begin
				apply_command(cmd, time_value, event_id);
				go = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(0, 6);
				end
			end
			if (!go && cmd_backlog.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!cmd_backlog[0].drain || reports_queued <= reports_seen) begin
					nx = cmd_backlog.pop_front();
					cmd        <= nx.c;
					time_value <= nx.tv;
					event_id   <= nx.id;
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	always @(posedge clk) begin : watch
		event_report_t er;
		if (arst_n && strobe) begin
			if (due_reports.size() == 0 || due_reports[0].acc_cyc >= cyc) begin
				report_error($sformatf("unexpected result status=%0d time=%h id=%h last=%b",
					status, out_time, out_id, last));
			end else begin
				er = due_reports.pop_front();
				if (status !== er.st)
					report_error($sformatf("status %0d, want %0d", status, er.st));
				if (out_time !== er.t)
					report_error($sformatf("out_time %h, want %h", out_time, er.t));
				if (out_id !== er.id)
					report_error($sformatf("out_id %h, want %h", out_id, er.id));
				if (last !== er.lst)
					report_error($sformatf("last %b, want %b", last, er.lst));
				reports_seen <= reports_seen + 1;
			end
		end
	end

	initial begin : stim
		logic [31:0] t;
		logic [15:0] id;
		int          n;
		int          k;
		arst_n = 1'b0;

		queue_cmd(CMD_LIST_ALL, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_LIST_AT, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_ADVANCE, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_ADD, 32'h0, 16'hFFFF, 1'b0);
		queue_cmd(CMD_REMOVE, 32'd5, 16'h0, 1'b0);
		queue_cmd(CMD_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_cmd(CMD_UNUSED_LO + 3'd1, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_UNUSED_HI, 32'hA5A5_5A5A, 16'h5A5A, 1'b0);
		queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_cmd(CMD_ADD, 32'd10, 16'h0000, 1'b0);
		queue_cmd(CMD_ADD, 32'd10, 16'h0000, 1'b0);
		queue_cmd(CMD_ADD, 32'd10, 16'h5555, 1'b0);
		queue_cmd(CMD_ADD, 32'd5, 16'hAAAA, 1'b0);
		queue_cmd(CMD_ADD, 32'd10, 16'h0000, 1'b0);
		queue_cmd(CMD_LIST_ALL, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_LIST_AT, 32'd10, 16'h0, 1'b0);
		queue_cmd(CMD_LIST_AT, 32'd7, 16'h0, 1'b0);
		queue_cmd(CMD_ADVANCE, 32'd10, 16'h0, 1'b0);
		queue_cmd(CMD_ADD, 32'd10, 16'h0001, 1'b0);
		queue_cmd(CMD_LIST_ALL, 32'h0, 16'h0, 1'b0);
		queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0, 1'b0);
		queue_cmd(CMD_ADVANCE, 32'hFFFF_FFF6, 16'h0, 1'b0);
		queue_cmd(CMD_ADD, 32'd1, 16'h1234, 1'b0);
		queue_cmd(CMD_ADVANCE, 32'hFFFF_FFFF, 16'h0, 1'b0);
		queue_cmd(CMD_ADVANCE, 32'd1, 16'h0, 1'b1);

		while (cmd_backlog.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(15, 19);
					repeat (n)
						queue_cmd(CMD_ADD, gen_now + $urandom_range(1, 24),
							($urandom_range(0, 3) == 0) ? 16'h0007 : 16'($urandom), 1'b0);
					queue_cmd(CMD_LIST_ALL, $urandom, 16'($urandom), 1'b1);
					queue_cmd(CMD_ADVANCE, $urandom_range(24, 40), 16'($urandom), 1'b0);
				end
				1: begin
					t  = gen_now + $urandom_range(1, 10);
					id = 16'($urandom);
					repeat ($urandom_range(2, 4))
						queue_cmd(CMD_ADD, t, id, 1'b0);
					queue_cmd(CMD_ADD, t, id ^ 16'h0001, 1'b0);
					queue_cmd(CMD_ADD, t + $urandom_range(0, 2), id, 1'b0);
					queue_cmd(CMD_LIST_AT, t, 16'($urandom), 1'b0);
					queue_cmd(CMD_ADVANCE, $urandom_range(10, 14), 16'($urandom), 1'b0);
				end
				default: begin
					k = $urandom_range(0, 19);
					if (k <= 6)
						queue_cmd(CMD_ADD, gen_now + $urandom_range(1, 64),
							16'($urandom), 1'b0);
					else if (k == 7)
						queue_cmd(CMD_ADD, $urandom, 16'($urandom), 1'b0);
					else if (k == 8)
						queue_cmd(CMD_ADD, gen_now - $urandom_range(0, 3),
							16'($urandom), 1'b0);
					else if (k <= 10)
						queue_cmd(CMD_REMOVE, recent_time(), 16'($urandom), 1'b0);
					else if (k <= 13)
						queue_cmd(CMD_ADVANCE, $urandom_range(0, 40), 16'($urandom), 1'b0);
					else if (k == 14)
						queue_cmd(CMD_ADVANCE, $urandom, 16'($urandom), 1'b0);
					else if (k == 15)
						queue_cmd(CMD_LIST_ALL, $urandom, 16'($urandom), 1'b0);
					else if (k <= 17)
						queue_cmd(CMD_LIST_AT, recent_time(), 16'($urandom), 1'b0);
					else if (k == 18)
						queue_cmd(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom,
							16'($urandom), 1'b0);
					else
						queue_cmd(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 1'b0);
				end
			endcase
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || reports_seen < reports_queued);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
